[design/ladsr_pkg.sv]
// Shared types, constants and the sequencer microcode for the linear ADSR envelope core.
// Depends on nothing; every other design file refers to it by scoped names.
package ladsr_pkg;

  // Default parameter values.
  localparam int COUNTER_BITS_DEF   = 32;
  localparam int GAIN_FRAC_BITS_DEF = 15;

  // Fixed field widths.
  localparam int REQ_BITS   = 2;
  localparam int DT_BITS    = 16;
  localparam int TICK_BITS  = 24;
  localparam int SUS_BITS   = 16;
  localparam int GAIN_BITS  = 16;
  localparam int PHASE_BITS = 3;

  // Register map.
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  // Register reset values.
  localparam logic [TICK_BITS-1:0] ATTACK_RST  = 24'd480;
  localparam logic [TICK_BITS-1:0] DECAY_RST   = 24'd4800;
  localparam logic [SUS_BITS-1:0]  SUSTAIN_RST = 16'd24576;
  localparam logic [TICK_BITS-1:0] RELEASE_RST = 24'd4800;

  // Request codes.
  localparam logic [REQ_BITS-1:0] REQ_ADVANCE  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_NOTE_OFF = 2'd2;

  // Phase codes.
  localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_DECAY   = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_SUSTAIN = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_DONE    = 3'd4;

  typedef struct packed {
    logic [REQ_BITS-1:0] req_type;
    logic [DT_BITS-1:0]  dt_ticks;
  } in_word_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0]  gain;
    logic [PHASE_BITS-1:0] phase;
    logic                  finished;
  } out_word_t;

  // Sequencer steps.
  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] ST_ACCEPT   = 3'd0;
  localparam logic [STEP_BITS-1:0] ST_CLASSIFY = 3'd1;
  localparam logic [STEP_BITS-1:0] ST_MUL      = 3'd2;
  localparam logic [STEP_BITS-1:0] ST_DIV      = 3'd3;
  localparam logic [STEP_BITS-1:0] ST_FINISH   = 3'd4;
  localparam logic [STEP_BITS-1:0] ST_RETURN   = 3'd5;

  // Datapath operations.
  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_ACCEPT   = 3'd1;
  localparam logic [2:0] OP_CLASSIFY = 3'd2;
  localparam logic [2:0] OP_MUL      = 3'd3;
  localparam logic [2:0] OP_DIV      = 3'd4;
  localparam logic [2:0] OP_FINISH   = 3'd5;

  // Jump conditions.
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_INPUT = 3'd2;
  localparam logic [2:0] C_NO_DIV   = 3'd3;
  localparam logic [2:0] C_DIV_MORE = 3'd4;
  localparam logic [2:0] C_OUT_BUSY = 3'd5;

  typedef struct packed {
    logic [2:0]           op;
    logic [2:0]           cond;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  // The control program. A step falls through to the next one unless its condition holds.
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    case (step)
      ST_ACCEPT:   w = '{op: OP_ACCEPT,   cond: C_NO_INPUT, target: ST_ACCEPT};
      ST_CLASSIFY: w = '{op: OP_CLASSIFY, cond: C_NO_DIV,   target: ST_FINISH};
      ST_MUL:      w = '{op: OP_MUL,      cond: C_NEVER,    target: ST_ACCEPT};
      ST_DIV:      w = '{op: OP_DIV,      cond: C_DIV_MORE, target: ST_DIV};
      ST_FINISH:   w = '{op: OP_FINISH,   cond: C_OUT_BUSY, target: ST_FINISH};
      ST_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_ACCEPT};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

[design/linear_adsr_envelope_core.sv]
// Top level of the linear ADSR envelope core: microcoded sequencer, datapath and APB registers.
// Depends on ladsr_pkg for types, constants and the control program.

// One voice of a linear ADSR envelope. Each input word (advance, note on or note off) updates
// the two saturating tick counters and the released flag, then yields one output word with the
// gain, phase and finished flag of the new state. A ramp takes the multiply and divide steps;
// sustain and finished skip them. The ramp gain needs one multiply followed by a restoring
// divider that settles one quotient bit per cycle. The next input word can be taken after the
// return step that follows the load into the output register, and the finishing step waits
// only while a previous result is still held there. The user must write registers through the
// APB port only while the core is idle; the core does not enforce this. pready is always high.
module linear_adsr_envelope_core #(
  parameter int COUNTER_BITS   = ladsr_pkg::COUNTER_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ladsr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ladsr_pkg::in_word_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ladsr_pkg::out_word_t              out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ladsr_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [ladsr_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [ladsr_pkg::PDATA_BITS-1:0]  prdata,
  output logic                              pready
);

  localparam int CB = COUNTER_BITS;
  localparam int TB = ladsr_pkg::TICK_BITS;
  localparam int BW = GAIN_FRAC_BITS + 1;   // gain and quotient width, holds ONE
  localparam int PW = TB + BW;              // product and remainder width
  localparam int CW = $clog2(BW);
  localparam logic [BW-1:0] ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  // Configuration registers.
  logic [TB-1:0]                   atk_q, dec_q, rel_ticks_q;
  logic [ladsr_pkg::SUS_BITS-1:0]  sus_q;
  logic                            cfg_we;
  logic [1:0]                      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_q       <= ladsr_pkg::ATTACK_RST;
      dec_q       <= ladsr_pkg::DECAY_RST;
      sus_q       <= ladsr_pkg::SUSTAIN_RST;
      rel_ticks_q <= ladsr_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ladsr_pkg::REG_ATTACK:  atk_q       <= pwdata[TB-1:0];
        ladsr_pkg::REG_DECAY:   dec_q       <= pwdata[TB-1:0];
        ladsr_pkg::REG_SUSTAIN: sus_q       <= pwdata[ladsr_pkg::SUS_BITS-1:0];
        ladsr_pkg::REG_RELEASE: rel_ticks_q <= pwdata[TB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ladsr_pkg::REG_ATTACK:  prdata = ladsr_pkg::PDATA_BITS'(atk_q);
      ladsr_pkg::REG_DECAY:   prdata = ladsr_pkg::PDATA_BITS'(dec_q);
      ladsr_pkg::REG_SUSTAIN: prdata = ladsr_pkg::PDATA_BITS'(sus_q);
      ladsr_pkg::REG_RELEASE: prdata = ladsr_pkg::PDATA_BITS'(rel_ticks_q);
      default:                prdata = '0;
    endcase
  end

  // Sustain level clamped to one.
  logic [BW-1:0] s_clamp;
  assign s_clamp = (32'(sus_q) > 32'(ONE)) ? ONE : BW'(sus_q);

  // Sequencer.
  logic [ladsr_pkg::STEP_BITS-1:0] step_q, step_d;
  ladsr_pkg::ucode_t               uc;
  logic                            take_jump;
  logic                            out_free;

  // Voice state and datapath registers.
  logic [CB-1:0]                   on_q, on_d, off_q, off_d;
  logic                            rel_q, rel_d;
  logic [ladsr_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic [TB-1:0]                   a_q, a_d, div_q, div_d;
  logic [BW-1:0]                   b_q, b_d, quo_q, quo_d;
  logic [PW-1:0]                   rem_q, rem_d, dsh_q, dsh_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  ladsr_pkg::out_word_t            out_data_q, out_data_d;

  // Combinational helpers.
  logic [CB:0]                     on_sum, off_sum;
  logic [CB-1:0]                   on_sat, off_sat, td;
  logic                            t_lt_a, td_lt_d, rel_done;
  logic [ladsr_pkg::PHASE_BITS-1:0] cls_phase;
  logic [PW-1:0]                   prod, rem_sub;
  logic                            ge;
  logic [BW-1:0]                   gain_w;
  logic [BW+ladsr_pkg::GAIN_BITS-1:0] gain_ext;

  assign uc         = ladsr_pkg::ucode_rom(step_q);
  assign in_ready_o = (uc.op == ladsr_pkg::OP_ACCEPT);
  assign out_free   = !out_valid_q || out_ready_i;

  assign on_sum  = {1'b0, on_q}  + (CB+1)'(in_data_i.dt_ticks);
  assign off_sum = {1'b0, off_q} + (CB+1)'(in_data_i.dt_ticks);
  assign on_sat  = on_sum[CB]  ? '1 : on_sum[CB-1:0];
  assign off_sat = off_sum[CB] ? '1 : off_sum[CB-1:0];

  assign td       = on_q - CB'(atk_q);
  assign t_lt_a   = on_q < CB'(atk_q);
  assign td_lt_d  = td < CB'(dec_q);
  assign rel_done = (rel_ticks_q == '0) || (off_q >= CB'(rel_ticks_q));

  always_comb begin
    if (!rel_q) begin
      if (t_lt_a)       cls_phase = ladsr_pkg::PH_ATTACK;
      else if (td_lt_d) cls_phase = ladsr_pkg::PH_DECAY;
      else              cls_phase = ladsr_pkg::PH_SUSTAIN;
    end else begin
      cls_phase = rel_done ? ladsr_pkg::PH_DONE : ladsr_pkg::PH_RELEASE;
    end
  end

  assign prod    = a_q * b_q;
  assign ge      = rem_q >= dsh_q;
  assign rem_sub = rem_q - dsh_q;

  always_comb begin
    case (phase_q)
      ladsr_pkg::PH_ATTACK:  gain_w = quo_q;
      ladsr_pkg::PH_RELEASE: gain_w = quo_q;
      ladsr_pkg::PH_DECAY:   gain_w = ONE - quo_q;
      ladsr_pkg::PH_SUSTAIN: gain_w = s_clamp;
      default:               gain_w = '0;
    endcase
  end
  assign gain_ext = (BW+ladsr_pkg::GAIN_BITS)'(gain_w);

  always_comb begin
    case (uc.cond)
      ladsr_pkg::C_NEVER:    take_jump = 1'b0;
      ladsr_pkg::C_ALWAYS:   take_jump = 1'b1;
      ladsr_pkg::C_NO_INPUT: take_jump = !in_valid_i;
      ladsr_pkg::C_NO_DIV:   take_jump = (cls_phase == ladsr_pkg::PH_SUSTAIN) ||
                                         (cls_phase == ladsr_pkg::PH_DONE);
      ladsr_pkg::C_DIV_MORE: take_jump = (cnt_q != '0);
      ladsr_pkg::C_OUT_BUSY: take_jump = !out_free;
      default:               take_jump = 1'b0;
    endcase
    step_d = take_jump ? uc.target : step_q + ladsr_pkg::STEP_BITS'(1);
  end

  always_comb begin
    on_d        = on_q;
    off_d       = off_q;
    rel_d       = rel_q;
    phase_d     = phase_q;
    a_d         = a_q;
    b_d         = b_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (uc.op)
      ladsr_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          case (in_data_i.req_type)
            ladsr_pkg::REQ_ADVANCE: begin
              on_d = on_sat;
              if (rel_q) off_d = off_sat;
            end
            ladsr_pkg::REQ_NOTE_ON: begin
              on_d  = '0;
              off_d = '0;
              rel_d = 1'b0;
            end
            ladsr_pkg::REQ_NOTE_OFF: begin
              if (!rel_q) begin
                rel_d = 1'b1;
                off_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ladsr_pkg::OP_CLASSIFY: begin
        phase_d = cls_phase;
        case (cls_phase)
          ladsr_pkg::PH_ATTACK: begin
            a_d   = on_q[TB-1:0];
            b_d   = ONE;
            div_d = atk_q;
          end
          ladsr_pkg::PH_DECAY: begin
            a_d   = td[TB-1:0];
            b_d   = ONE - s_clamp;
            div_d = dec_q;
          end
          default: begin
            // Only the release ramp remains to divide; the other phases skip the divider.
            a_d   = rel_ticks_q - off_q[TB-1:0];
            b_d   = s_clamp;
            div_d = rel_ticks_q;
          end
        endcase
      end
      ladsr_pkg::OP_MUL: begin
        rem_d = prod;
        dsh_d = PW'(div_q) << (BW - 1);
        quo_d = '0;
        cnt_d = CW'(BW - 1);
      end
      ladsr_pkg::OP_DIV: begin
        // The quotient never exceeds one, so BW bits of restoring division suffice.
        if (ge) rem_d = rem_sub;
        quo_d = {quo_q[BW-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - CW'(1);
      end
      ladsr_pkg::OP_FINISH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.gain     = gain_ext[ladsr_pkg::GAIN_BITS-1:0];
          out_data_d.phase    = phase_q;
          out_data_d.finished = (phase_q == ladsr_pkg::PH_DONE);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ladsr_pkg::ST_ACCEPT;
      on_q        <= '1;
      off_q       <= '1;
      rel_q       <= 1'b1;
      phase_q     <= ladsr_pkg::PH_DONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      on_q        <= on_d;
      off_q       <= off_d;
      rel_q       <= rel_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    dsh_q      <= dsh_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The finished flag and the done phase always travel together.
  a_fin_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.finished == (out_data_o.phase == ladsr_pkg::PH_DONE)))
    else $error("finished flag disagrees with phase");

  // An accepted word is always followed by classification.
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (step_q == ladsr_pkg::ST_CLASSIFY))
    else $error("sequencer did not move to classification after accept");

  // A new result appears only from the finishing step.
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(step_q) == ladsr_pkg::ST_FINISH))
    else $error("output loaded outside the finishing step");

  // A note on restarts the voice.
  a_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.req_type == ladsr_pkg::REQ_NOTE_ON))
    |=> ((on_q == '0) && (off_q == '0) && !rel_q))
    else $error("note on did not clear the voice state");

endmodule
